### design/rf3_pkg.sv
// rf3_pkg: shared types, register codes and compare helpers for the 3x3 rank filter
// used by rf3_line_store, rf3_rank and rank_filter_3x3_core; depends on nothing

package rf3_pkg;

    // window geometry
    localparam int WIN      = 3;
    localparam int TAPS     = WIN * WIN;
    localparam int MIN_SIZE = 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SIZE_W     = 11;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd2;

    // filter modes, any other code filters as median
    localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIN    = 2'd2;

    typedef logic [7:0] pix_t;
    typedef pix_t [TAPS-1:0] window_t;

    // one line store entry: previous line and the line before it
    typedef struct packed {
        pix_t prev2;
        pix_t prev1;
    } line_word_t;

    // per result control carried down the rank pipeline
    typedef struct packed {
        logic interior;
        logic last;
    } item_ctl_t;

    typedef struct packed {
        pix_t hi;
        pix_t mid;
        pix_t lo;
    } sort3_t;

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // three compare-exchanges
    function automatic sort3_t sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t   l1;
        pix_t   h1;
        pix_t   t;
        sort3_t s;
        l1    = min2(a, b);
        h1    = max2(a, b);
        s.lo  = min2(l1, c);
        t     = max2(l1, c);
        s.mid = min2(h1, t);
        s.hi  = max2(h1, t);
        return s;
    endfunction

endpackage

### design/rf3_line_store.sv
// rf3_line_store: dual line store as one synchronous memory, one read and one write port
// depends on rf3_pkg for the entry type

module rf3_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output rf3_pkg::line_word_t rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  rf3_pkg::line_word_t wr_data
);

    rf3_pkg::line_word_t line_mem [DEPTH];
    rf3_pkg::line_word_t rd_data_reg;

    // read returns the old entry when the same address is written in that cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/rf3_rank.sv
// rf3_rank: three stage rank pipeline (row sort, candidates, final pick into output register)
// depends on rf3_pkg for window, control types and compare helpers

module rf3_rank (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [rf3_pkg::MODE_W-1:0] filter_mode,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  rf3_pkg::window_t         in_window,
    input  rf3_pkg::item_ctl_t       in_ctl,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rf3_pkg::pix_t            out_pixel,
    output logic                     out_last
);

    typedef struct packed {
        rf3_pkg::sort3_t [rf3_pkg::WIN-1:0] rows;
        rf3_pkg::pix_t                      center;
        rf3_pkg::item_ctl_t                 ctl;
    } s1_t;

    typedef struct packed {
        rf3_pkg::pix_t [2:0]  cand;
        logic                 use_median;
        rf3_pkg::pix_t        center;
        rf3_pkg::item_ctl_t   ctl;
    } s2_t;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    rf3_pkg::pix_t out_pixel_reg, out_pixel_next;
    logic out_last_reg, out_last_next;

    logic out_free, rdy2, adv1, adv2, load1;

    // stage handshakes, bubbles collapse
    assign out_free = !out_valid_reg || out_ready;
    assign rdy2     = !s2_valid_reg || out_free;
    assign adv2     = s2_valid_reg && out_free;
    assign adv1     = s1_valid_reg && rdy2;
    assign in_ready = !s1_valid_reg || rdy2;
    assign load1    = in_valid && in_ready;

    // stage 1: sort each window row
    always_comb begin
        for (int r = 0; r < rf3_pkg::WIN; r++) begin
            s1_next.rows[r] = rf3_pkg::sort3(in_window[r*rf3_pkg::WIN],
                                             in_window[r*rf3_pkg::WIN + 1],
                                             in_window[r*rf3_pkg::WIN + 2]);
        end
        s1_next.center = in_window[rf3_pkg::TAPS/2];
        s1_next.ctl    = in_ctl;
    end

    // stage 2: candidates per mode
    always_comb begin
        s2_next.center = s1_reg.center;
        s2_next.ctl    = s1_reg.ctl;
        unique case (filter_mode)
            rf3_pkg::MODE_MAX: begin
                s2_next.cand[0]    = rf3_pkg::max3(s1_reg.rows[0].hi, s1_reg.rows[1].hi,
                                                   s1_reg.rows[2].hi);
                s2_next.cand[1]    = s1_reg.rows[0].hi;
                s2_next.cand[2]    = s1_reg.rows[0].hi;
                s2_next.use_median = 1'b0;
            end
            rf3_pkg::MODE_MIN: begin
                s2_next.cand[0]    = rf3_pkg::min3(s1_reg.rows[0].lo, s1_reg.rows[1].lo,
                                                   s1_reg.rows[2].lo);
                s2_next.cand[1]    = s1_reg.rows[0].lo;
                s2_next.cand[2]    = s1_reg.rows[0].lo;
                s2_next.use_median = 1'b0;
            end
            default: begin
                s2_next.cand[0]    = rf3_pkg::max3(s1_reg.rows[0].lo, s1_reg.rows[1].lo,
                                                   s1_reg.rows[2].lo);
                s2_next.cand[1]    = rf3_pkg::med3(s1_reg.rows[0].mid, s1_reg.rows[1].mid,
                                                   s1_reg.rows[2].mid);
                s2_next.cand[2]    = rf3_pkg::min3(s1_reg.rows[0].hi, s1_reg.rows[1].hi,
                                                   s1_reg.rows[2].hi);
                s2_next.use_median = 1'b1;
            end
        endcase
    end

    // stage 3: final pick, border pixels pass through
    always_comb begin
        if (!s2_reg.ctl.interior) begin
            out_pixel_next = s2_reg.center;
        end else if (s2_reg.use_median) begin
            out_pixel_next = rf3_pkg::med3(s2_reg.cand[0], s2_reg.cand[1], s2_reg.cand[2]);
        end else begin
            out_pixel_next = s2_reg.cand[0];
        end
        out_last_next = s2_reg.ctl.last;
    end

    // valid flags
    always_comb begin
        s1_valid_next  = load1 ? 1'b1 : (adv1 ? 1'b0 : s1_valid_reg);
        s2_valid_next  = adv1 ? 1'b1 : (adv2 ? 1'b0 : s2_valid_reg);
        out_valid_next = adv2 ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load1) begin
            s1_reg <= s1_next;
        end
        if (adv1) begin
            s2_reg <= s2_next;
        end
        if (adv2) begin
            out_pixel_reg <= out_pixel_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

`ifndef ASSERT_OFF
    // back pressure reaches the input only when every later stage is full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (s2_valid_reg && out_valid_reg))
        else $error("rank input stalled with a free stage downstream");

    // a beat moved out of stage 2 lands in the output register
    a_adv2_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 |=> out_valid_reg)
        else $error("stage 2 beat lost");

    // a beat moved out of stage 1 lands in stage 2
    a_adv1_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        adv1 |=> s2_valid_reg)
        else $error("stage 1 beat lost");
`endif

endmodule

### design/rank_filter_3x3_core.sv
// rank_filter_3x3_core: top level of the 3x3 median / max / min filter for 8-bit grey frames
// depends on rf3_pkg, rf3_line_store and rf3_rank

// Takes one pixel beat per clock in raster order and returns one result beat per clock
// at a sustained rate of one pixel per cycle while m_tready is held high; the rate is
// set by the line store memory, which is read at one port and written back at the
// other for every pixel, with the write of one pixel forwarded to a read of the same
// entry in the next beat. A result follows its input by image_width + 1 beats and then
// passes the read stage register and the rank pipeline registers. The first
// image_width + 1 beats of a frame give no result; after the last pixel, send
// image_width + 1 beats with s_tuser (pad) set to drain the frame; m_tlast marks the last
// pixel of the frame. Border pixels pass through unchanged. Line stores need no clearing
// pass. Write the size and mode registers only while the block is idle; a size write starts a new frame.

module rank_filter_3x3_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [rf3_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [rf3_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_in
    input  logic                            s_tuser,   // [0] pad
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] pixel_out
    output logic                            m_tlast    // frame_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int SZA = (WW > rf3_pkg::SIZE_W) ? WW : rf3_pkg::SIZE_W;
    localparam int SZW = (HW > SZA) ? HW : SZA;

    localparam logic [1:0] ROWS_NONE = 2'd0;
    localparam logic [1:0] ROWS_ONE  = 2'd1;
    localparam logic [1:0] ROWS_FULL = 2'd2;

    // configuration registers
    logic [rf3_pkg::SIZE_W-1:0] image_width_reg;
    logic [rf3_pkg::SIZE_W-1:0] image_height_reg;
    logic [rf3_pkg::MODE_W-1:0] filter_mode_reg;

    // raster position
    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    rows_reg, rows_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    // read stage
    logic                a_valid_reg, a_valid_next;
    rf3_pkg::pix_t       a_pix_reg;
    logic [CW-1:0]       a_col_reg;
    logic                a_emit_reg;
    rf3_pkg::item_ctl_t  a_ctl_reg;
    logic                fwd_hit_reg;
    rf3_pkg::line_word_t fwd_word_reg;

    rf3_pkg::window_t    window_reg, window_next;

    logic [SZW-1:0]      width_ext, height_ext;
    logic [WW-1:0]       w_eff;
    logic [HW-1:0]       h_eff;
    logic [WW-1:0]       c_plus, oc_plus;
    logic [HW-1:0]       or_plus;
    logic                col_wrap, emit, interior, last;
    logic                accept, adv_a, size_write;
    logic                rank_ready;
    rf3_pkg::line_word_t rd_word, mem_word, wr_word;
    rf3_pkg::item_ctl_t  ctl_now;

    // clamp frame size to 3..MAX
    always_comb begin
        width_ext  = SZW'(image_width_reg);
        height_ext = SZW'(image_height_reg);
        if (width_ext < SZW'(rf3_pkg::MIN_SIZE)) begin
            w_eff = WW'(rf3_pkg::MIN_SIZE);
        end else if (width_ext > SZW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = width_ext[WW-1:0];
        end
        if (height_ext < SZW'(rf3_pkg::MIN_SIZE)) begin
            h_eff = HW'(rf3_pkg::MIN_SIZE);
        end else if (height_ext > SZW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = height_ext[HW-1:0];
        end
    end

    // handshakes: non-result beats leave the read stage at once
    assign adv_a    = a_valid_reg && (!a_emit_reg || rank_ready);
    assign s_tready = aresetn && (!a_valid_reg || adv_a);
    assign accept   = s_tvalid && s_tready;

    // position decode for the accepted beat
    always_comb begin
        c_plus   = WW'(col_reg) + WW'(1);
        oc_plus  = WW'(out_col_reg) + WW'(1);
        or_plus  = HW'(out_row_reg) + HW'(1);
        col_wrap = (c_plus >= w_eff);
        emit     = (rows_reg == ROWS_FULL) || ((rows_reg == ROWS_ONE) && (col_reg != '0));
        interior = (out_row_reg != '0) && (or_plus < h_eff) &&
                   (out_col_reg != '0) && (oc_plus < w_eff);
        last     = (or_plus == h_eff) && (oc_plus == w_eff);
        ctl_now.interior = interior;
        ctl_now.last     = last;
    end

    // next raster position
    always_comb begin
        col_next     = col_reg;
        rows_next    = rows_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept) begin
            if (col_wrap) begin
                col_next  = '0;
                rows_next = (rows_reg == ROWS_FULL) ? ROWS_FULL : rows_reg + 2'd1;
            end else begin
                col_next  = c_plus[CW-1:0];
            end
            if (emit) begin
                if (last) begin
                    col_next     = '0;
                    rows_next    = ROWS_NONE;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (oc_plus == w_eff) begin
                    out_col_next = '0;
                    out_row_next = or_plus[RW-1:0];
                end else begin
                    out_col_next = oc_plus[CW-1:0];
                end
            end
        end
    end

    // configuration decode
    assign size_write = cfg_wr_en &&
        ((cfg_wr_index == rf3_pkg::REG_IMAGE_WIDTH) ||
         (cfg_wr_index == rf3_pkg::REG_IMAGE_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= rf3_pkg::SIZE_W'(640);
            image_height_reg <= rf3_pkg::SIZE_W'(480);
            filter_mode_reg  <= rf3_pkg::MODE_MEDIAN;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                rf3_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data;
                rf3_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data;
                rf3_pkg::REG_FILTER_MODE:  filter_mode_reg  <= cfg_wr_data[rf3_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // position counters, a size write restarts the frame
    always_ff @(posedge aclk) begin
        if (!aresetn || size_write) begin
            col_reg     <= '0;
            rows_reg    <= ROWS_NONE;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            col_reg     <= col_next;
            rows_reg    <= rows_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // line store entry for the beat in the read stage, with write forwarding
    assign mem_word = fwd_hit_reg ? fwd_word_reg : rd_word;
    always_comb begin
        wr_word.prev2 = mem_word.prev1;
        wr_word.prev1 = a_pix_reg;
    end

    rf3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_word),
        .wr_en   (adv_a),
        .wr_addr (a_col_reg),
        .wr_data (wr_word)
    );

    // read stage valid
    assign a_valid_next = accept ? 1'b1 : (adv_a ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    // read stage payload; pad beats count as zero pixels
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pix_reg    <= s_tuser ? 8'd0 : s_tdata;
            a_col_reg    <= col_reg;
            a_emit_reg   <= emit;
            a_ctl_reg    <= ctl_now;
            fwd_hit_reg  <= adv_a && (a_col_reg == col_reg);
            fwd_word_reg <= wr_word;
        end
    end

    // window shift with the new column from the line store
    always_comb begin
        for (int r = 0; r < rf3_pkg::WIN; r++) begin
            window_next[r*rf3_pkg::WIN]     = window_reg[r*rf3_pkg::WIN + 1];
            window_next[r*rf3_pkg::WIN + 1] = window_reg[r*rf3_pkg::WIN + 2];
        end
        window_next[2] = mem_word.prev2;
        window_next[5] = mem_word.prev1;
        window_next[8] = a_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (adv_a) begin
            window_reg <= window_next;
        end
    end

    rf3_rank u_rank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .filter_mode (filter_mode_reg),
        .in_valid    (a_valid_reg && a_emit_reg),
        .in_ready    (rank_ready),
        .in_window   (window_next),
        .in_ctl      (a_ctl_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pixel   (m_tdata),
        .out_last    (m_tlast)
    );

`ifndef ASSERT_OFF
    // input column always inside the configured line
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(col_reg) < w_eff)
        else $error("column counter past line width");

    // output row always inside the configured frame
    a_out_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        HW'(out_row_reg) < h_eff)
        else $error("output row past frame height");

    // row state saturates at two full lines
    a_rows_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_reg != 2'd3)
        else $error("row state out of range");

    // a beat accepted over an occupied read stage means that stage drains now
    a_read_stage_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && a_valid_reg) |-> adv_a)
        else $error("read stage overwritten");
`endif

endmodule

### tb/sv/tb_rank_filter_3x3_core.sv
// tb_rank_filter_3x3_core: self-checking testbench for the 3x3 median / max / min filter core
// a filter model or directed table predicts each result, checked in order against the core
// depends on rf3_pkg and rank_filter_3x3_core

module tb_rank_filter_3x3_core;

    localparam int FRAME_MAX      = 1024;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int SETTLE_CYCLES  = 12;
    localparam int STALL_AFTER    = 100;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_MAX   = 2000;
    localparam int RESET_BEATS    = 16;
    localparam int RANDOM_BEATS   = 360;
    localparam int OVERSIZE_BEATS = 16;
    localparam int TALL_BEATS     = 30;
    localparam int PLAN_ROWS      = 25;

    // index with no register behind it, writes must be ignored
    localparam logic [rf3_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        rf3_pkg::pix_t pixel;
        logic          frame_end;
    } px_result_t;

    typedef enum logic {ROW_REG, ROW_BEAT} plan_kind_t;

    typedef struct packed {
        plan_kind_t                     kind;
        logic [rf3_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [rf3_pkg::CFG_DATA_W-1:0] value;
        logic                           pad;
        logic                           checked;
        rf3_pkg::pix_t                  want_pix;
        logic                           want_end;
    } plan_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [rf3_pkg::CFG_IDX_W-1:0]  cfg_wr_index;
    logic [rf3_pkg::CFG_DATA_W-1:0] cfg_wr_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [7:0]                     m_tdata;
    logic                           m_tlast;

    rank_filter_3x3_core #(
        .MAX_WIDTH  (FRAME_MAX),
        .MAX_HEIGHT (FRAME_MAX)
    ) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // filter model state
    rf3_pkg::pix_t              row_above  [FRAME_MAX];
    rf3_pkg::pix_t              row_above2 [FRAME_MAX];
    rf3_pkg::pix_t              win [rf3_pkg::TAPS];
    int unsigned                in_col;
    int unsigned                in_row;
    int unsigned                out_idx;
    int unsigned                reg_width;
    int unsigned                reg_height;
    logic [rf3_pkg::MODE_W-1:0] reg_mode;

    px_result_t         expected_pixels [$];

    int unsigned        beats_sent;
    int unsigned        results_seen;
    int unsigned        frames_seen;
    int unsigned        reg_writes;
    int unsigned        errors;
    int unsigned        idle_cycles = 0;
    int                 send_run;
    bit                 send_calm;

    function automatic plan_row_t set_reg(logic [rf3_pkg::CFG_IDX_W-1:0] idx,
                                          logic [rf3_pkg::CFG_DATA_W-1:0] value);
        return '{ROW_REG, idx, value, 1'b0, 1'b0, 8'd0, 1'b0};
    endfunction

    function automatic plan_row_t pixel_row(rf3_pkg::pix_t pixel, logic pad);
        return '{ROW_BEAT, '0, {3'd0, pixel}, pad, 1'b0, 8'd0, 1'b0};
    endfunction

    function automatic plan_row_t pixel_want(rf3_pkg::pix_t pixel, logic pad,
                                             rf3_pkg::pix_t want, logic last);
        return '{ROW_BEAT, '0, {3'd0, pixel}, pad, 1'b1, want, last};
    endfunction

    // 3x5 frame, sizes clamped from a zero width; results lag four beats, so the
    // expected value of a border result is the pixel sent four beats earlier
    plan_row_t direct_plan [PLAN_ROWS] = '{
        set_reg(rf3_pkg::REG_IMAGE_WIDTH, 11'd0),
        set_reg(rf3_pkg::REG_IMAGE_HEIGHT, 11'd5),
        set_reg(rf3_pkg::REG_FILTER_MODE, 11'd3),
        set_reg(REG_UNUSED, 11'h7FF),
        pixel_row(8'd0, 1'b0),
        pixel_row(8'd255, 1'b0),
        pixel_row(8'd10, 1'b0),
        pixel_row(8'd20, 1'b0),
        pixel_want(8'd30, 1'b0, 8'd0, 1'b0),
        pixel_want(8'd40, 1'b0, 8'd255, 1'b0),
        pixel_want(8'd50, 1'b0, 8'd10, 1'b0),
        pixel_want(8'hAA, 1'b1, 8'd20, 1'b0),     // pad inside the frame acts as zero
        pixel_row(8'd200, 1'b0),                  // first interior result, median
        set_reg(rf3_pkg::REG_FILTER_MODE, {9'd0, rf3_pkg::MODE_MAX}),
        pixel_want(8'd128, 1'b0, 8'd40, 1'b0),
        pixel_want(8'd7, 1'b0, 8'd50, 1'b0),
        pixel_row(8'd99, 1'b0),                   // interior result, maximum
        set_reg(rf3_pkg::REG_FILTER_MODE, {9'd0, rf3_pkg::MODE_MIN}),
        pixel_want(8'd255, 1'b0, 8'd200, 1'b0),
        pixel_want(8'd1, 1'b0, 8'd128, 1'b0),
        pixel_row(8'd77, 1'b0),                   // interior result, minimum
        pixel_want(8'd0, 1'b1, 8'd99, 1'b0),
        pixel_want(8'h55, 1'b0, 8'd255, 1'b0),    // real pixel during the drain
        pixel_want(8'd0, 1'b1, 8'd1, 1'b0),
        pixel_want(8'hFF, 1'b1, 8'd77, 1'b1)
    };

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < rf3_pkg::MIN_SIZE) return rf3_pkg::MIN_SIZE;
        if (v > FRAME_MAX) return FRAME_MAX;
        return v;
    endfunction

    // rank of the current window under the current mode, codes other than max/min are median
    function automatic rf3_pkg::pix_t window_rank();
        rf3_pkg::pix_t s [rf3_pkg::TAPS];
        rf3_pkg::pix_t key;
        int            j;
        s = win;
        if (reg_mode == rf3_pkg::MODE_MAX) begin
            key = s[0];
            for (int i = 1; i < rf3_pkg::TAPS; i++) if (s[i] > key) key = s[i];
            return key;
        end
        if (reg_mode == rf3_pkg::MODE_MIN) begin
            key = s[0];
            for (int i = 1; i < rf3_pkg::TAPS; i++) if (s[i] < key) key = s[i];
            return key;
        end
        for (int i = 1; i < rf3_pkg::TAPS; i++) begin
            key = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > key) begin
                s[j + 1] = s[j];
                j--;
            end
            s[j + 1] = key;
        end
        return s[rf3_pkg::TAPS / 2];
    endfunction

    task automatic model_reset();
        foreach (row_above[i]) begin
            row_above[i]  = '0;
            row_above2[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        in_col     = 0;
        in_row     = 0;
        out_idx    = 0;
        reg_width  = RESET_WIDTH;
        reg_height = RESET_HEIGHT;
        reg_mode   = rf3_pkg::MODE_MEDIAN;
    endtask

    task automatic model_reg_write(input logic [rf3_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [rf3_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            rf3_pkg::REG_IMAGE_WIDTH:  reg_width  = value;
            rf3_pkg::REG_IMAGE_HEIGHT: reg_height = value;
            rf3_pkg::REG_FILTER_MODE:  reg_mode   = value[rf3_pkg::MODE_W-1:0];
            default: ;
        endcase
        // a size write starts a new frame
        if (idx == rf3_pkg::REG_IMAGE_WIDTH || idx == rf3_pkg::REG_IMAGE_HEIGHT) begin
            in_col  = 0;
            in_row  = 0;
            out_idx = 0;
        end
    endtask

    // one pixel beat through the model: shifts the window, updates the line stores
    task automatic filter_pixel(input rf3_pkg::pix_t pixel, input logic pad,
                                output logic has_result, output px_result_t res);
        int unsigned   w;
        int unsigned   h;
        int unsigned   c;
        int unsigned   r;
        int unsigned   orow;
        int unsigned   ocol;
        rf3_pkg::pix_t v;
        logic          interior;
        w = clamp_dim(reg_width);
        h = clamp_dim(reg_height);
        v = pad ? '0 : pixel;
        c = (in_col >= w) ? 0 : in_col;
        r = in_row;
        for (int k = 0; k < rf3_pkg::WIN; k++) begin
            win[k * rf3_pkg::WIN]     = win[k * rf3_pkg::WIN + 1];
            win[k * rf3_pkg::WIN + 1] = win[k * rf3_pkg::WIN + 2];
        end
        win[2]        = row_above2[c];
        win[5]        = row_above[c];
        win[8]        = v;
        row_above2[c] = row_above[c];
        row_above[c]  = v;
        has_result = (r >= 2) || (r == 1 && c >= 1);
        if (c + 1 >= w) begin
            in_col = 0;
            in_row = r + 1;
        end else begin
            in_col = c + 1;
        end
        res = '0;
        if (has_result) begin
            orow          = out_idx / w;
            ocol          = out_idx % w;
            interior      = orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w;
            res.pixel     = interior ? window_rank() : win[4];
            res.frame_end = (out_idx + 1 >= w * h);
            if (res.frame_end) begin
                out_idx = 0;
                in_col  = 0;
                in_row  = 0;
            end else begin
                out_idx++;
            end
        end
    endtask

    // gap before the next beat; runs of random gaps and runs of none, each kind picked at random
    function automatic int next_gap(inout int run_left, inout bit calm);
        if (run_left <= 0) begin
            run_left = $urandom_range(8, 40);
            calm     = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : int'($urandom_range(0, 5));
    endfunction

    task automatic send_beat(input rf3_pkg::pix_t pixel, input logic pad,
                             input logic typed = 1'b0, input px_result_t typed_res = '0);
        int         gap;
        logic       has_result;
        px_result_t res;
        gap = next_gap(send_run, send_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        s_tuser  <= pad;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        filter_pixel(pixel, pad, has_result, res);
        if (typed) begin
            expected_pixels.push_back(typed_res);
        end else if (has_result) begin
            expected_pixels.push_back(res);
        end
    endtask

    task automatic send_pixels(input int unsigned count, input bit noisy);
        for (int unsigned i = 0; i < count; i++)
            send_beat(8'($urandom_range(0, 255)), noisy && ($urandom_range(0, 19) == 0));
    endtask

    // width + 1 pad beats flush the frame; a real pixel here still counts as a drain beat
    task automatic send_drain(input bit noisy);
        int unsigned w;
        w = clamp_dim(reg_width);
        for (int unsigned i = 0; i <= w; i++)
            send_beat(8'($urandom_range(0, 255)), !(noisy && $urandom_range(0, 3) == 0));
    endtask

    // hold the input until every pending result is out, then let the pipeline settle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [rf3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rf3_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        model_reg_write(idx, value);
        reg_writes++;
    endtask

    task automatic check_result(input rf3_pkg::pix_t pixel, input logic frame_end);
        px_result_t want;
        results_seen++;
        if (frame_end === 1'b1) frames_seen++;
        if (expected_pixels.size() == 0) begin
            $error("result beat with nothing pending: pixel_out %0d frame_end %0b",
                   pixel, frame_end);
            errors++;
            return;
        end
        want = expected_pixels.pop_front();
        if (pixel !== want.pixel) begin
            $error("pixel_out mismatch: expected %0d, got %0d", want.pixel, pixel);
            errors++;
        end
        if (frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, got %0b", want.frame_end, frame_end);
            errors++;
        end
    endtask

    // result side: random backpressure plus one long hold, taken while the sender
    // is still offering beats so the core fills up
    initial begin : result_sink
        int gap;
        int run_left;
        bit calm;
        bit held;
        run_left = 0;
        calm     = 1'b0;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = next_gap(run_left, calm);
            @(negedge aclk);
            if (!held && results_seen >= STALL_AFTER && s_tvalid === 1'b1) begin
                held = 1'b1;
                gap  = STALL_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_result(m_tdata, m_tlast);
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("no beat moved for %0d cycles", WATCHDOG_MAX);
            $display("rank_filter_3x3_core verification failed");
            $finish;
        end
    end

    // stimulus
    initial begin : pixel_source
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned cut;
        int unsigned random_start;
        px_result_t  want;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        beats_sent   = 0;
        results_seen = 0;
        frames_seen  = 0;
        reg_writes   = 0;
        errors       = 0;
        send_run     = 0;
        send_calm    = 1'b0;
        model_reset();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // a few beats at the reset size, too early in the line to give any result
        send_pixels(RESET_BEATS, 1'b1);

        // directed table
        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (direct_plan[i].kind == ROW_REG) begin
                wait_drained();
                write_reg(direct_plan[i].reg_idx, direct_plan[i].value);
            end else begin
                want.pixel     = direct_plan[i].want_pix;
                want.frame_end = direct_plan[i].want_end;
                send_beat(direct_plan[i].value[7:0], direct_plan[i].pad,
                          direct_plan[i].checked, want);
            end
        end

        // random small frames, some broken off, some with a mode change mid-frame
        random_start = beats_sent;
        while (beats_sent < random_start + RANDOM_BEATS) begin
            wait_drained();
            write_reg(rf3_pkg::REG_IMAGE_WIDTH, ($urandom_range(0, 7) == 0) ?
                      11'($urandom_range(0, 2)) : 11'($urandom_range(3, 8)));
            write_reg(rf3_pkg::REG_IMAGE_HEIGHT, ($urandom_range(0, 7) == 0) ?
                      11'($urandom_range(0, 2)) : 11'($urandom_range(3, 6)));
            if ($urandom_range(0, 1) == 1)
                write_reg(rf3_pkg::REG_FILTER_MODE, 11'($urandom_range(0, 3)));
            w     = clamp_dim(reg_width);
            h     = clamp_dim(reg_height);
            total = w * h;
            if ($urandom_range(0, 7) == 0) begin
                // abandoned frame, the next size write restarts
                send_pixels($urandom_range(1, total - 1), 1'b1);
            end else if ($urandom_range(0, 3) == 0) begin
                cut = $urandom_range(w + 2, total - 1);
                send_pixels(cut, 1'b1);
                wait_drained();
                write_reg(rf3_pkg::REG_FILTER_MODE, 11'($urandom_range(0, 3)));
                send_pixels(total - cut, 1'b1);
                send_drain(1'b1);
            end else begin
                send_pixels(total, 1'b1);
                send_drain(1'b1);
            end
        end

        // registers above the maximum: widest line gives no result this early,
        // then a narrow line over the tallest frame, both broken off
        wait_drained();
        write_reg(rf3_pkg::REG_IMAGE_WIDTH, 11'h7FF);
        write_reg(rf3_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
        write_reg(rf3_pkg::REG_FILTER_MODE, {9'd0, rf3_pkg::MODE_MIN});
        send_pixels(OVERSIZE_BEATS, 1'b0);
        wait_drained();
        write_reg(rf3_pkg::REG_IMAGE_WIDTH, 11'd3);
        write_reg(rf3_pkg::REG_FILTER_MODE, {9'd0, rf3_pkg::MODE_MAX});
        send_pixels(TALL_BEATS, 1'b0);

        // wind down and catch any stray result beats
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("sent %0d pixel beats, %0d register writes: directed, random, oversize",
                 beats_sent, reg_writes);
        $display("checked %0d result beats over %0d frames in all modes, %0d mismatches",
                 results_seen, frames_seen, errors);
        if (errors == 0) begin
            $display("rank_filter_3x3_core verification clean");
        end else begin
            $display("rank_filter_3x3_core verification failed");
        end
        $finish;
    end

endmodule
